[rtl/core/pfrf_pkg.sv]
`default_nettype none

package pfrf_pkg;

    // page geometry
    localparam int PAGE_BYTES = 1024;
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);
    localparam int CNT_W      = PAGE_AW + 1;

    // fixed field widths
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 10;
    localparam int LEN_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 11;
    localparam int STAT_W  = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FIT   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] start_address;
        logic              from_anywhere;
        logic [LEN_W-1:0]  run_length;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_FIRST,
        S_FIT,
        S_CNT_ALL,
        S_CNT_RUN,
        S_DONE
    } t_state;

    function automatic logic [VALUE_W-1:0] sat_value(input logic [CNT_W-1:0] v);
        logic [VALUE_W-1:0] r;
        if (32'(v) > 32'(VALUE_MAX)) begin
            r = VALUE_MAX;
        end else begin
            r = VALUE_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pfrf_page_mem.sv]
`default_nettype none

module pfrf_page_mem
    import pfrf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [PAGE_AW-1:0] i_waddr,
    input  wire logic [BYTE_W-1:0]  i_wdata,
    input  wire logic [PAGE_AW-1:0] i_raddr,
    output logic      [BYTE_W-1:0]  o_rdata
);

    logic [BYTE_W-1:0] r_mem [PAGE_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, one address per cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/page_free_run_finder.sv]
// channel   | dir | handshake                | payload
// ----------+-----+--------------------------+------------------------------
// in        | in  | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
// out       | out | o_out_valid / i_out_ready| o_out_item (t_out_item)
// cfg       | in  | i_cfg_valid / o_cfg_ready| i_cfg_data (empty code)
//
// one item at a time; every byte visit goes through the single read port of
// the page memory and one shared free-byte compare, so scans run one byte a cycle
// write, bad address, unused kind go straight to the result; read does one memory read
// clear writes each cleared byte; count scans up to PAGE_BYTES bytes
// fit: first-empty pass, then, unless from_anywhere, run pass from the fit start
// after reset a clearing pass zeroes every byte of the page; o_in_ready
// stays low during it, cfg beats are always taken
// a result waits in the output register while the next item is taken

`default_nettype none

module page_free_run_finder
    import pfrf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;          // next address to issue
    logic                r_pend, n_pend;        // read data of r_pidx arrives now
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_empty_code;

    // payload
    t_in_item            r_item, n_item;
    logic [PAGE_AW-1:0]  r_pidx, n_pidx;
    logic [CNT_W-1:0]    r_end, n_end;
    logic [CNT_W-1:0]    r_run, n_run;
    logic [PAGE_AW-1:0]  r_run_start, n_run_start;
    logic [CNT_W-1:0]    r_count, n_count;
    t_out_item           r_res, n_res;
    t_out_item           r_out, n_out;

    // memory port
    logic                w_we;
    logic [PAGE_AW-1:0]  w_waddr;
    logic [BYTE_W-1:0]   w_wdata;
    logic [PAGE_AW-1:0]  w_raddr;
    logic [BYTE_W-1:0]   w_rdata;

    // decode of the offered item
    logic                w_accept;
    logic                w_addr_ok;
    logic                w_uses_addr;
    logic                w_bad_addr;
    logic                w_known_kind;
    logic [31:0]         w_clear_end;

    // shared scan signals
    logic                w_free;
    logic                w_busy_byte;
    logic                w_scan_end;
    logic [LEN_W-1:0]    w_want;
    logic                w_fit_hit;
    logic [PAGE_AW-1:0]  w_fit_start;
    logic                w_out_free;

    pfrf_page_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_addr_ok    = 32'(i_in_item.start_address) < 32'(PAGE_BYTES);
    assign w_uses_addr  = (i_in_item.kind == KIND_WRITE) || (i_in_item.kind == KIND_READ)
                       || (i_in_item.kind == KIND_CLEAR)
                       || (((i_in_item.kind == KIND_FIT) || (i_in_item.kind == KIND_COUNT))
                           && !i_in_item.from_anywhere);
    assign w_bad_addr   = w_uses_addr && !w_addr_ok;
    assign w_known_kind = (i_in_item.kind == KIND_READ) || (i_in_item.kind == KIND_CLEAR)
                       || (i_in_item.kind == KIND_FIT) || (i_in_item.kind == KIND_COUNT);
    assign w_clear_end  = 32'(i_in_item.start_address) + 32'(i_in_item.run_length);

    // one compare serves every scan
    assign w_free      = r_pend && (w_rdata == r_empty_code);
    assign w_busy_byte = r_pend && (w_rdata != r_empty_code);
    assign w_scan_end  = !r_pend && (32'(r_idx) == 32'(PAGE_BYTES));

    // a zero run length asks for one byte
    assign w_want      = (r_item.run_length == '0) ? LEN_W'(1) : r_item.run_length;
    assign w_fit_hit   = w_free && ((32'(r_run) + 32'd1) >= 32'(w_want));
    // fit pass starts at the later of the start address and the first empty
    assign w_fit_start = (32'(r_item.start_address) > 32'(r_pidx))
                       ? PAGE_AW'(r_item.start_address) : r_pidx;

    assign w_out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (32'(r_idx) == 32'(PAGE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_bad_addr || !w_known_kind) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_in_item.kind)
                            KIND_READ:  n_state = S_READ;
                            KIND_CLEAR: n_state = S_CLEAR;
                            KIND_FIT:   n_state = S_FIRST;
                            KIND_COUNT: n_state = i_in_item.from_anywhere ? S_CNT_ALL : S_CNT_RUN;
                            default:    n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                if (r_idx >= r_end) begin
                    n_state = S_DONE;
                end
            end
            S_FIRST: begin
                if (w_free) begin
                    n_state = r_item.from_anywhere ? S_DONE : S_FIT;
                end else if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_FIT: begin
                if (w_fit_hit || w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_CNT_ALL: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_CNT_RUN: begin
                if (w_busy_byte || w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_item      = r_item;
        n_end       = r_end;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_idx[PAGE_AW-1:0];
        w_wdata     = r_empty_code;
        w_raddr     = r_idx[PAGE_AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // address issue shared by all scan states
        if ((r_state == S_FIRST) || (r_state == S_FIT)
            || (r_state == S_CNT_ALL) || (r_state == S_CNT_RUN)) begin
            if (32'(r_idx) != 32'(PAGE_BYTES)) begin
                n_pend = 1'b1;
                n_pidx = r_idx[PAGE_AW-1:0];
                n_idx  = r_idx + CNT_W'(1);
            end
        end

        case (r_state)
            S_INIT: begin
                // page reset value is zero, not the current empty code
                w_we    = 1'b1;
                w_wdata = '0;
                n_idx   = r_idx + CNT_W'(1);
            end
            S_IDLE: begin
                w_raddr = PAGE_AW'(i_in_item.start_address);
                w_waddr = PAGE_AW'(i_in_item.start_address);
                w_wdata = i_in_item.data_byte;
                if (w_accept) begin
                    n_item       = i_in_item;
                    n_res.value  = '0;
                    n_res.status = w_bad_addr ? STAT_BAD_ADDR : STAT_OK;
                    n_run        = '0;
                    n_count      = '0;
                    n_idx        = '0;
                    w_we         = (i_in_item.kind == KIND_WRITE) && !w_bad_addr;
                    if (i_in_item.kind == KIND_CLEAR) begin
                        n_idx = CNT_W'(i_in_item.start_address);
                        n_end = (w_clear_end > 32'(PAGE_BYTES))
                              ? CNT_W'(PAGE_BYTES) : CNT_W'(w_clear_end);
                    end else if ((i_in_item.kind == KIND_COUNT) && !i_in_item.from_anywhere) begin
                        n_idx = CNT_W'(i_in_item.start_address);
                    end
                end
            end
            S_READ: begin
                n_res.value = VALUE_W'(w_rdata);
            end
            S_CLEAR: begin
                if (r_idx < r_end) begin
                    w_we  = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_res.value = sat_value(r_end - CNT_W'(r_item.start_address));
                end
            end
            S_FIRST: begin
                if (w_free) begin
                    if (r_item.from_anywhere) begin
                        n_res.value = sat_value(CNT_W'(r_pidx));
                    end else begin
                        // drop the read in flight and restart at the fit start
                        n_idx  = CNT_W'(w_fit_start);
                        n_pend = 1'b0;
                        n_run  = '0;
                    end
                end else if (w_scan_end) begin
                    n_res.status = STAT_NO_EMPTY;
                end
            end
            S_FIT: begin
                if (w_free) begin
                    if (r_run == '0) begin
                        n_run_start = r_pidx;
                    end
                    n_run = r_run + CNT_W'(1);
                    if (w_fit_hit) begin
                        n_res.value = sat_value(CNT_W'((r_run == '0) ? r_pidx : r_run_start));
                    end
                end else if (w_busy_byte) begin
                    n_run = '0;
                end else if (w_scan_end) begin
                    n_res.status = STAT_NO_FIT;
                end
            end
            S_CNT_ALL: begin
                if (w_free) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_scan_end) begin
                    n_res.value = sat_value(r_count);
                end
            end
            S_CNT_RUN: begin
                if (w_free) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_busy_byte || w_scan_end) begin
                    n_res.value = sat_value(r_count);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_empty_code <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_empty_code <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_pidx      <= n_pidx;
        r_end       <= n_end;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_count     <= n_count;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

[rtl/core/pfrf_checker.sv]
`default_nettype none

module pfrf_checker
    import pfrf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_out_item         o_out_item
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // one item at a time: taking a beat closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    // any failure status carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != STAT_OK) |-> (o_out_item.value == '0))
        else $error("failure status with nonzero value");

    // the page clearing pass keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input open right after reset");

endmodule

bind page_free_run_finder pfrf_checker u_pfrf_checker (.*);

`default_nettype wire
